@@ design/skt_pkg.sv @@
package skt_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;

  typedef enum logic [1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT,
    ST_WRITE,
    ST_READ,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [KEY_WIDTH-1:0] key;
    logic [IDX_W-1:0]            read_index;
  } skt_in_t;

  typedef struct packed {
    logic                        found;
    logic [CNT_W-1:0]            position;
    logic signed [KEY_WIDTH-1:0] entry_value;
    logic [CNT_W-1:0]            entries_now;
    status_e                     status;
  } skt_out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } skt_ctl_t;

endpackage

@@ design/skt_ram.sv @@
module skt_ram
  import skt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IDX_W-1:0]     waddr_i,
  input  logic [KEY_WIDTH-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [IDX_W-1:0]     raddr_i,
  output logic [KEY_WIDTH-1:0] rdata_o
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/skt_engine.sv @@
module skt_engine
  import skt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  skt_in_t  item_i,
  input  logic     res_take_i,
  output skt_ctl_t ctl_o,
  output skt_out_t res_o
);

  state_e state_q, state_d;

  kind_e                       kind_q, kind_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic [IDX_W-1:0]            ridx_q, ridx_d;
  logic [CNT_W-1:0]            lo_q, lo_d;
  logic [CNT_W-1:0]            hx_q, hx_d;
  logic [IDX_W-1:0]            mid_q, mid_d;
  logic                        found_q, found_d;
  logic [CNT_W-1:0]            pos_q, pos_d;
  logic [CNT_W-1:0]            sh_q, sh_d;
  logic                        wpend_q, wpend_d;
  logic [IDX_W-1:0]            wadr_q, wadr_d;
  logic signed [KEY_WIDTH-1:0] val_q, val_d;
  status_e                     status_q, status_d;
  logic [CNT_W-1:0]            count_q, count_d;

  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0] mem_wdata, mem_rdata;

  logic [CNT_W:0]       mid_sum;
  logic [IDX_W-1:0]     mid_calc;
  logic [CNT_W-1:0]     sh_dec;
  logic                 probe_live, key_lt, key_gt, key_eq;
  logic                 search_end, do_shift;
  logic [CNT_W-1:0]     end_pos;

  skt_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The probe window is [lo, hx); mid equals (low + high) / 2 with high = hx - 1.
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hx_q} - {{CNT_W{1'b0}}, 1'b1};
  assign mid_calc   = mid_sum[IDX_W:1];
  assign probe_live = (lo_q < hx_q);
  assign sh_dec     = sh_q - {{(CNT_W-1){1'b0}}, 1'b1};

  assign key_lt = (key_q < $signed(mem_rdata));
  assign key_gt = (key_q > $signed(mem_rdata));
  assign key_eq = !key_lt && !key_gt;

  assign search_end = ((state_q == ST_PROBE) && !probe_live) ||
                      ((state_q == ST_CMP) && key_eq);
  assign end_pos    = (state_q == ST_PROBE) ? lo_q : {1'b0, mid_q};
  assign do_shift   = (kind_q == KIND_INSERT) && (count_q < CNT_W'(CAPACITY));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (kind_e'(item_i.kind))
            KIND_SEARCH, KIND_INSERT: state_d = ST_PROBE;
            KIND_READ:                state_d = ST_READ;
            KIND_NONE:                state_d = ST_DONE;
          endcase
        end
      end
      ST_PROBE, ST_CMP: begin
        if (search_end) begin
          state_d = do_shift ? ST_SHIFT : ST_DONE;
        end else begin
          state_d = (state_q == ST_PROBE) ? ST_CMP : ST_PROBE;
        end
      end
      ST_SHIFT: begin
        if (sh_q <= pos_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE:  state_d = ST_DONE;
      ST_READ:   state_d = ({1'b0, ridx_q} < count_q) ? ST_RDWAIT : ST_DONE;
      ST_RDWAIT: state_d = ST_DONE;
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory port control and status outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wadr_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = mid_calc;
    unique case (state_q)
      ST_PROBE: begin
        mem_re    = probe_live;
        mem_raddr = mid_calc;
      end
      ST_SHIFT: begin
        mem_we    = wpend_q;
        mem_waddr = wadr_q;
        mem_wdata = mem_rdata;
        mem_re    = (sh_q > pos_q);
        mem_raddr = sh_dec[IDX_W-1:0];
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[IDX_W-1:0];
        mem_wdata = key_q;
      end
      ST_READ: begin
        mem_re    = ({1'b0, ridx_q} < count_q);
        mem_raddr = ridx_q;
      end
      default: begin
      end
    endcase
  end

  assign ctl_o.idle = (state_q == ST_IDLE);
  assign ctl_o.done = (state_q == ST_DONE);

  assign res_o.found       = found_q;
  assign res_o.position    = pos_q;
  assign res_o.entry_value = val_q;
  assign res_o.entries_now = count_q;
  assign res_o.status      = status_q;

  // Datapath registers.
  always_comb begin
    kind_d   = kind_q;
    key_d    = key_q;
    ridx_d   = ridx_q;
    lo_d     = lo_q;
    hx_d     = hx_q;
    mid_d    = mid_q;
    found_d  = found_q;
    pos_d    = pos_q;
    sh_d     = sh_q;
    wpend_d  = 1'b0;
    wadr_d   = wadr_q;
    val_d    = val_q;
    status_d = status_q;
    count_d  = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_d   = kind_e'(item_i.kind);
          key_d    = item_i.key;
          ridx_d   = item_i.read_index;
          lo_d     = '0;
          hx_d     = count_q;
          found_d  = 1'b0;
          pos_d    = '0;
          val_d    = '0;
          status_d = STATUS_OK;
        end
      end
      ST_PROBE: begin
        mid_d = mid_calc;
      end
      ST_CMP: begin
        if (key_lt) begin
          hx_d = {1'b0, mid_q};
        end else if (key_gt) begin
          lo_d = {1'b0, mid_q} + {{(CNT_W-1){1'b0}}, 1'b1};
        end else begin
          found_d = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (sh_q > pos_q) begin
          wpend_d = 1'b1;
          wadr_d  = sh_q[IDX_W-1:0];
          sh_d    = sh_dec;
        end
      end
      ST_WRITE: begin
        count_d = count_q + {{(CNT_W-1){1'b0}}, 1'b1};
      end
      ST_READ: begin
        if ({1'b0, ridx_q} >= count_q) begin
          status_d = STATUS_RANGE;
        end
      end
      ST_RDWAIT: begin
        val_d = $signed(mem_rdata);
      end
      default: begin
      end
    endcase

    if (search_end) begin
      pos_d   = end_pos;
      sh_d    = count_q;
      wpend_d = 1'b0;
      if (kind_q == KIND_INSERT && !do_shift) begin
        status_d = STATUS_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wpend_q <= wpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    key_q    <= key_d;
    ridx_q   <= ridx_d;
    lo_q     <= lo_d;
    hx_q     <= hx_d;
    mid_q    <= mid_d;
    found_q  <= found_d;
    pos_q    <= pos_d;
    sh_q     <= sh_d;
    wadr_q   <= wadr_d;
    val_q    <= val_d;
    status_q <= status_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_only_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_SHIFT || state_q == ST_WRITE))
    else $error("store written outside an insert");

  a_write_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (count_q < CNT_W'(CAPACITY)))
    else $error("insert into a full table");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("count did not advance after insert");

  a_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (lo_q <= hx_q))
    else $error("probe window inverted");

endmodule

@@ design/sorted_key_table.sv @@
// Sorted key table: keeps up to 64 signed 32-bit keys in ascending order in a
// single-port-write, single-port-read synchronous memory.
// Input channel: in_valid_i, in_stall_o, in_data_i (kind, key, read_index).
// A transaction is accepted on a rising edge with valid high and stall low.
// The block works on one transaction at a time and stalls the input while busy.
// Output channel: out_valid_o, out_stall_i, out_data_o; exactly one result
// per input transaction, in order.
// From acceptance to the result in the output register: a search runs up to
// 7 probes, each a memory read in the probe state and a compare in the compare
// state, and ends on an empty window or an equal key. An insert then moves each
// entry from the position up by one slot, one move per shift step, and stores
// the key in the write state; an insert into a full table only searches. A read
// fetches the entry, or reports a range status when the index is beyond the
// count; the unused kind goes straight to the result. No new transaction is
// taken until the result has left the engine and it is back in idle.
// Reset clears the entry count and all control state; no clearing pass of the
// key memory is needed, since only entries below the count are ever read.
// When the receiver stalls, the result holds in the output register and the
// block may accept and finish one more transaction, which then waits inside.
module sorted_key_table
  import skt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  skt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output skt_out_t out_data_o
);

  skt_ctl_t ctl;
  skt_out_t res;
  logic     start;
  logic     take;

  logic     out_valid_q, out_valid_d;
  skt_out_t out_data_q, out_data_d;

  // The engine takes new work only from its idle state.
  assign in_stall_o = !ctl.idle;
  assign start      = in_valid_i && ctl.idle;

  // A finished result moves into the output register when it is empty or
  // its current content leaves this cycle.
  assign take = ctl.done && (!out_valid_q || !out_stall_i);

  skt_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_data_i),
    .res_take_i (take),
    .ctl_o      (ctl),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ tb/sorted_key_table_test.sv @@
// Self-checking testbench for the sorted key table. Stimulus drives search, insert,
// read and unused-kind transactions through a valid/stall channel. A scoreboard
// keeps its own sorted copy of the table and predicts each result. Every result
// that leaves the block is compared field by field against the oldest prediction.
module sorted_key_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  // The worst correct run is roughly 1800 transactions, plus random gaps and
  // stalls. The limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 1_000_000;
  // The longest insert searches a table of 63 keys (the most it holds when it
  // shifts), moves every stored entry, writes the key and passes the result into
  // the output register. This drain covers that with room to spare.
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS = 445;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  // Scoreboard: mirrors the sorted table and holds the predicted results in
  // order of acceptance.
  class key_table_scoreboard;
    key_t       keys [CAPACITY];
    int         count;
    skt_out_t   pending [$];
    int         errors;
    int         checked;
    int         hits;
    int         rejected_full;
    int         reads_beyond;

    // Binary search with a signed compare. It returns 1 on an equal key and
    // leaves the probed index in slot. Otherwise slot is the insertion point.
    function automatic bit find_slot(key_t k, output int slot);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = count - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (k < keys[mid]) begin
          hi = mid - 1;
        end else if (k > keys[mid]) begin
          lo = mid + 1;
        end else begin
          slot = mid;
          return 1'b1;
        end
      end
      slot = lo;
      return 1'b0;
    endfunction

    function automatic void note_input(skt_in_t t);
      skt_out_t exp;
      int       slot;
      exp = '0;
      case (t.kind)
        KIND_SEARCH, KIND_INSERT: begin
          exp.found    = find_slot(t.key, slot);
          exp.position = slot[CNT_W-1:0];
          if (exp.found) hits++;
          if (t.kind == KIND_INSERT) begin
            if (count >= CAPACITY) begin
              exp.status = STATUS_FULL;
              rejected_full++;
            end else begin
              for (int i = count; i > slot; i--) keys[i] = keys[i-1];
              keys[slot] = t.key;
              count++;
            end
          end
        end
        KIND_READ: begin
          if (int'(t.read_index) < count) begin
            exp.entry_value = keys[t.read_index];
          end else begin
            exp.status = STATUS_RANGE;
            reads_beyond++;
          end
        end
        default: ;
      endcase
      exp.entries_now = count[CNT_W-1:0];
      pending.push_back(exp);
    endfunction

    function automatic void report(string field, longint e, longint a);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, e, a);
      errors++;
    endfunction

    function automatic void check_result(skt_out_t got);
      skt_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result with no transaction outstanding, got %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.found !== exp.found) report("found", exp.found, got.found);
      if (got.position !== exp.position) report("position", exp.position, got.position);
      if (got.entry_value !== exp.entry_value) begin
        report("entry_value", exp.entry_value, got.entry_value);
      end
      if (got.entries_now !== exp.entries_now) begin
        report("entries_now", exp.entries_now, got.entries_now);
      end
      if (got.status !== exp.status) report("status", exp.status, got.status);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  skt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  skt_out_t out_data;

  key_table_scoreboard sb = new;
  int accepted = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  sorted_key_table u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver decides at each falling edge whether to stall the next edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sample both channels at the rising edge. Values driven at the falling edge
  // are stable here, and the block's outputs still show their pre-edge values.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, sb.pending.size());
      $display("sorted_key_table test failed");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_data);
        accepted++;
      end
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Present one transaction and hold it until the block takes it. This task is
  // entered and left at a falling edge. A random gap may come first. During the
  // gap valid is low, and it is driven high again only at a later edge.
  task automatic send_item(input skt_in_t t);
    int target;
    target = accepted + 1;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(negedge clk); while (accepted < target);
  endtask

  function automatic skt_in_t item_of(kind_e k, key_t key, int unsigned idx);
    skt_in_t t;
    t.kind       = k;
    t.key        = key;
    t.read_index = idx[IDX_W-1:0];
    return t;
  endfunction

  // Keys come from a small dense range to give duplicates and near misses, from
  // the extremes of the signed range, from keys already stored (and their
  // neighbors), or from the full 32-bit space.
  function automatic key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel <= 2) begin
      return key_t'($urandom_range(16)) - 8;
    end else if (sel == 3) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return -1;
        3: return 0;
        4: return 32'sh8000_0001;
        default: return 32'sh7FFF_FFFE;
      endcase
    end else if (sel <= 6 && sb.count > 0) begin
      return sb.keys[$urandom_range(sb.count - 1)] + key_t'($urandom_range(2)) - 1;
    end
    return key_t'($urandom);
  endfunction

  // Most random traffic is searches and reads against a table that grows
  // through occasional inserts. The table fills during the run, so later
  // inserts exercise the full-table rejection. A few unused kinds are mixed in.
  task automatic send_random(input int n);
    skt_in_t     t;
    int unsigned r;
    int unsigned ins_pct;
    repeat (n) begin
      r = $urandom_range(99);
      ins_pct = (sb.count < CAPACITY) ? 10 : 5;
      t.key = pick_key();
      t.read_index = IDX_W'($urandom_range(CAPACITY - 1));
      if (r < ins_pct) begin
        t.kind = KIND_INSERT;
      end else if (r < 60) begin
        t.kind = KIND_SEARCH;
      end else if (r < 97) begin
        t.kind = KIND_READ;
        if (sb.count > 0 && $urandom_range(99) < 70) begin
          t.read_index = IDX_W'($urandom_range(sb.count - 1));
        end
      end else begin
        t.kind = KIND_NONE;
      end
      send_item(t);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Phase one: no idling on either side. The directed transactions come
    // first. They cover an empty table, reads beyond the count, the unused
    // kind, inserts of the extreme keys and of a duplicate, and searches that
    // hit both ends and fall between stored keys.
    send_item(item_of(KIND_SEARCH, 0, 0));
    send_item(item_of(KIND_READ, 0, 0));
    send_item(item_of(KIND_READ, 0, 63));
    send_item(item_of(KIND_NONE, -1, 63));
    send_item(item_of(KIND_INSERT, 0, 0));
    send_item(item_of(KIND_INSERT, 32'sh7FFF_FFFF, 63));
    send_item(item_of(KIND_INSERT, 32'sh8000_0000, 0));
    send_item(item_of(KIND_INSERT, -1, 21));
    send_item(item_of(KIND_INSERT, 0, 42));
    send_item(item_of(KIND_INSERT, 1, 0));
    send_item(item_of(KIND_SEARCH, 32'sh8000_0000, 63));
    send_item(item_of(KIND_SEARCH, 32'sh7FFF_FFFF, 0));
    send_item(item_of(KIND_SEARCH, 0, 0));
    send_item(item_of(KIND_SEARCH, 5, 0));
    send_item(item_of(KIND_SEARCH, -2, 0));
    send_item(item_of(KIND_SEARCH, 32'sh7FFF_FFFE, 0));
    send_item(item_of(KIND_READ, 32'sh5555_5555, 0));
    send_item(item_of(KIND_READ, 0, 5));
    send_item(item_of(KIND_READ, 0, 6));
    send_item(item_of(KIND_READ, 0, 63));
    send_item(item_of(KIND_NONE, 32'sh2AAA_AAAA, 42));
    send_random(PHASE_ITEMS - 21);

    // Phase two: the sender leaves gaps most of the time.
    send_idle_pct = 55;
    send_random(PHASE_ITEMS);

    // Phase three: the receiver stalls most of the time.
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    send_random(PHASE_ITEMS);

    // Phase four: both sides idle a quarter of the time.
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    send_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // Let the block settle so that any extra result still shows up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions and checked %0d results; the table ended with %0d keys.",
             accepted, sb.checked, sb.count);
    $display("Probes met an equal key %0d times, %0d inserts hit a full table, %0d reads %s",
             sb.hits, sb.rejected_full, sb.reads_beyond, "were past the count.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sorted_key_table test passed");
    end else begin
      $display("sorted_key_table test failed");
    end
    $finish;
  end

endmodule
